// ===== hw/rtl/tmm_pkg.sv =====
// Typed message mailbox: shared types, widths and codes.
// No dependencies; tmm_seq and typed_message_mailbox_unit import this package.
package tmm_pkg;

    localparam int DEPTH   = 8;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TYPE_W  = 16;
    localparam int DATA_W  = 16;
    localparam int HELD_W  = 4;
    localparam int ENTRY_W = TYPE_W + DATA_W;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_GET  = 1'b1;

    localparam logic [1:0] ST_SENT      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic              op;
        logic [TYPE_W-1:0] msg_type;
        logic [DATA_W-1:0] msg_content;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] out_content;
        logic [HELD_W-1:0] held_count;
    } rsp_t;

    typedef struct packed {
        logic [TYPE_W-1:0] msg_type;
        logic [DATA_W-1:0] msg_content;
    } entry_t;

endpackage

// ===== hw/rtl/tmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module tmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/tmm_seq.sv =====
// Mailbox sequencer: message count, oldest-first type scan and compaction
// through the entry RAM. Depends on tmm_pkg and tmm_ram.
module tmm_seq
    import tmm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_fire,
    input  req_t req,
    output logic busy,
    output logic res_valid,
    output rsp_t res,
    input  logic res_take
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_MOVE = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [TYPE_W-1:0] key_reg, key_next;
    rsp_t              res_reg, res_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;

    logic [CNT_W:0] ptr_p1, ptr_p2, cnt_ext;
    logic [CNT_W-1:0] cnt_dec;

    tmm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign ptr_p1  = {1'b0, ptr_reg} + (CNT_W+1)'(1);
    assign ptr_p2  = {1'b0, ptr_reg} + (CNT_W+1)'(2);
    assign cnt_ext = {1'b0, count_reg};
    assign cnt_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg[IDX_W-1:0];
        wr_data    = rd_data;
        rd_addr    = ptr_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                if (req_fire)
                begin
                    res_next.out_content = '0;
                    if (req.op == OP_SEND)
                    begin
                        state_next = S_DONE;
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            res_next.status     = ST_FULL;
                            res_next.held_count = HELD_W'(count_reg);
                        end
                        else
                        begin
                            wr_en               = 1'b1;
                            wr_addr             = count_reg[IDX_W-1:0];
                            wr_data.msg_type    = req.msg_type;
                            wr_data.msg_content = req.msg_content;
                            count_next          = count_reg + CNT_W'(1);
                            res_next.status     = ST_SENT;
                            res_next.held_count = HELD_W'(count_reg + CNT_W'(1));
                        end
                    end
                    else
                    begin
                        key_next = req.msg_type;
                        ptr_next = '0;
                        if (count_reg == '0)
                        begin
                            res_next.status     = ST_NOT_FOUND;
                            res_next.held_count = HELD_W'(count_reg);
                            state_next          = S_DONE;
                        end
                        else
                        begin
                            state_next = S_CMP;
                        end
                    end
                end
            end

            // rd_data holds the entry at ptr_reg
            S_CMP:
            begin
                if (rd_data.msg_type == key_reg)
                begin
                    res_next.out_content = rd_data.msg_content;
                    if (ptr_p1 < cnt_ext)
                    begin
                        rd_addr    = ptr_p1[IDX_W-1:0];
                        state_next = S_MOVE;
                    end
                    else
                    begin
                        count_next          = cnt_dec;
                        res_next.status     = ST_FOUND;
                        res_next.held_count = HELD_W'(cnt_dec);
                        state_next          = S_DONE;
                    end
                end
                else if (ptr_p1 < cnt_ext)
                begin
                    ptr_next = ptr_p1[CNT_W-1:0];
                    rd_addr  = ptr_p1[IDX_W-1:0];
                end
                else
                begin
                    res_next.status      = ST_NOT_FOUND;
                    res_next.out_content = '0;
                    res_next.held_count  = HELD_W'(count_reg);
                    state_next           = S_DONE;
                end
            end

            // rd_data holds the entry at ptr_reg + 1; move it down one place
            S_MOVE:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_p1[CNT_W-1:0];
                if (ptr_p2 < cnt_ext)
                begin
                    rd_addr = ptr_p2[IDX_W-1:0];
                end
                else
                begin
                    count_next          = cnt_dec;
                    res_next.status     = ST_FOUND;
                    res_next.held_count = HELD_W'(cnt_dec);
                    state_next          = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

// ===== hw/rtl/typed_message_mailbox_unit.sv =====
// Typed message mailbox top level: request/response handshakes and the
// response output register. Depends on tmm_pkg and tmm_seq.
//
//  channel | signals                   | beat carries
//  --------+---------------------------+----------------------------------
//  req     | req_valid, req_stall, req | op, msg_type, msg_content
//  rsp     | rsp_valid, rsp_stall, rsp | status, out_content, held_count
//
// One request at a time. A send is registered in the sequencer's result
// register and then in the output register; a get first compares k entries
// and moves m later entries down, one RAM read per cycle. k + m never
// exceeds the count. The finished result waits in the sequencer until the
// output register is free; req_stall stays high until the output register
// has taken it. Reset clears the count; RAM contents are not cleared.
module typed_message_mailbox_unit
    import tmm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic req_fire;
    logic busy;
    logic res_valid;
    logic res_take;
    rsp_t res;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;

    assign req_stall = busy;
    assign req_fire  = req_valid && !busy;
    assign res_take  = res_valid && (!rsp_valid_reg || !rsp_stall);

    tmm_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_fire (req_fire),
        .req      (req),
        .busy     (busy),
        .res_valid(res_valid),
        .res      (res),
        .res_take (res_take)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
